### src/htfd_pkg.sv
// Shared constants, codes and helper functions for the humidity/temperature frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

    // CRC-8 settings: polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // byte positions within one six-byte frame
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUM_CRC  = 2'd2
    } t_status;

    // conversion scales: value = floor(scale * raw / 65535) - offset
    localparam logic [14:0] T_SCALE  = 15'd17500;
    localparam logic [14:0] T_OFFSET = 15'd4500;
    localparam logic [13:0] H_SCALE  = 14'd12500;
    localparam logic [13:0] H_OFFSET = 14'd600;
    localparam logic [13:0] H_MAX    = 14'd10000;

    // field widths of a result
    localparam int TEMP_W = 15;
    localparam int HUM_W  = 14;
    localparam int RAW_W  = 16;
    localparam int PROD_W = 31;

    // one byte through the CRC-8 register, eight bit steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31: x = q0*65536 + lo, so
    // x - q0*65535 = lo + q0, which stays below twice the divisor
    function automatic logic [14:0] div_65535(input logic [PROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[30:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + ((rem >= 17'd65535) ? 15'd1 : 15'd0);
    endfunction

endpackage

`default_nettype wire

### src/humidity_temp_frame_decoder_top.sv
// Top level of the humidity/temperature frame decoder: byte framing, CRC check and conversion.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tdata[7:0] frame byte; tuser[0] frame start
//  m_axis   | out | tdata temperature, humidity, raw words; tuser[1:0] status
//
// One byte beat can be taken every cycle while the input is not stalled. The sixth
// byte of a frame loads a result stage; the converted result then moves into the
// output register, which drives the result beat.
// Reset (synchronous, active low) clears the byte position, the CRC and the
// stage valid flags. A stalled output holds its beat; input stalls only when
// both the result stage and the output register are full and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] frame_byte
    input  wire logic        s_axis_tuser,  // [0] frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi,
                                            // [44:29] temperature_raw, [60:45] humidity_raw,
                                            // [63:61] zero
    output logic [1:0]       m_axis_tuser   // [1:0] status
);

    // frame state
    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp_word, n_temp_word;
    logic [15:0] r_hum_word, n_hum_word;
    logic        r_temp_bad, n_temp_bad;

    // result stage between framing and conversion
    logic        r_a_valid;
    logic [1:0]  r_a_status, n_a_status;
    logic [15:0] r_a_traw;
    logic [15:0] r_a_hraw;

    // output register
    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic [htfd_pkg::TEMP_W-1:0] r_o_temp;
    logic [htfd_pkg::HUM_W-1:0]  r_o_hum;
    logic [15:0] r_o_traw;
    logic [15:0] r_o_hraw;

    logic        w_in_beat;
    logic        w_out_free;
    logic        w_a_free;
    logic        w_frame_done;
    logic [2:0]  w_pos;
    logic [7:0]  w_crc_base;
    logic [7:0]  w_crc_upd;

    logic [htfd_pkg::PROD_W-1:0] w_t_prod;
    logic [htfd_pkg::PROD_W-1:0] w_h_prod;
    logic [14:0] w_t_quot;
    logic [14:0] w_h_quot_full;
    logic [13:0] w_h_quot;
    logic [htfd_pkg::TEMP_W-1:0] w_temp;
    logic [htfd_pkg::HUM_W-1:0]  w_hum;

    // flow control
    assign w_out_free    = !r_o_valid || m_axis_tready;
    assign w_a_free      = !r_a_valid || w_out_free;
    assign s_axis_tready = w_a_free;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;

    // effective position: frame start or an unused code restarts the frame
    assign w_pos = (s_axis_tuser || (r_pos > htfd_pkg::POS_H_CRC)) ? htfd_pkg::POS_T_MSB : r_pos;
    assign w_crc_base = ((w_pos == htfd_pkg::POS_T_MSB) || (w_pos == htfd_pkg::POS_H_MSB))
                        ? htfd_pkg::CRC_INIT : r_crc;
    assign w_crc_upd  = htfd_pkg::crc8_byte(w_crc_base, s_axis_tdata);

    // per-byte framing
    always_comb begin
        n_pos        = w_pos + 3'd1;
        n_crc        = w_crc_upd;
        n_temp_word  = r_temp_word;
        n_hum_word   = r_hum_word;
        n_temp_bad   = r_temp_bad;
        n_a_status   = htfd_pkg::ST_OK;
        w_frame_done = 1'b0;
        case (w_pos)
            htfd_pkg::POS_T_MSB: begin
                n_temp_word = {s_axis_tdata, 8'h00};
            end
            htfd_pkg::POS_T_LSB: begin
                n_temp_word = {r_temp_word[15:8], s_axis_tdata};
            end
            htfd_pkg::POS_T_CRC: begin
                n_crc      = r_crc;
                n_temp_bad = (r_crc != s_axis_tdata);
            end
            htfd_pkg::POS_H_MSB: begin
                n_hum_word = {s_axis_tdata, 8'h00};
            end
            htfd_pkg::POS_H_LSB: begin
                n_hum_word = {r_hum_word[15:8], s_axis_tdata};
            end
            default: begin
                // humidity CRC byte closes the frame
                w_frame_done = 1'b1;
                n_pos        = htfd_pkg::POS_T_MSB;
                n_crc        = htfd_pkg::CRC_INIT;
                n_temp_bad   = 1'b0;
                if (r_temp_bad) begin
                    n_a_status = htfd_pkg::ST_TEMP_CRC;
                end else if (r_crc != s_axis_tdata) begin
                    n_a_status = htfd_pkg::ST_HUM_CRC;
                end else begin
                    n_a_status = htfd_pkg::ST_OK;
                end
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= htfd_pkg::POS_T_MSB;
            r_crc      <= htfd_pkg::CRC_INIT;
            r_temp_bad <= 1'b0;
        end else if (w_in_beat) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_temp_bad <= n_temp_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_temp_word <= n_temp_word;
            r_hum_word  <= n_hum_word;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= w_in_beat && w_frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free && w_in_beat && w_frame_done) begin
            r_a_status <= n_a_status;
            r_a_traw   <= r_temp_word;
            r_a_hraw   <= r_hum_word;
        end
    end

    // conversion: constant multiply, divide by 65535, offset and clamp; a CRC error zeroes both values
    assign w_t_prod      = htfd_pkg::PROD_W'(htfd_pkg::T_SCALE) * htfd_pkg::PROD_W'(r_a_traw);
    assign w_h_prod      = htfd_pkg::PROD_W'(htfd_pkg::H_SCALE) * htfd_pkg::PROD_W'(r_a_hraw);
    assign w_t_quot      = htfd_pkg::div_65535(w_t_prod);
    assign w_h_quot_full = htfd_pkg::div_65535(w_h_prod);
    assign w_h_quot      = w_h_quot_full[13:0];

    always_comb begin
        w_temp = w_t_quot - htfd_pkg::T_OFFSET;
        if (w_h_quot < htfd_pkg::H_OFFSET) begin
            w_hum = '0;
        end else if (w_h_quot > (htfd_pkg::H_MAX + htfd_pkg::H_OFFSET)) begin
            w_hum = htfd_pkg::H_MAX;
        end else begin
            w_hum = w_h_quot - htfd_pkg::H_OFFSET;
        end
        if (r_a_status != htfd_pkg::ST_OK) begin
            w_temp = '0;
            w_hum  = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_a_valid) begin
            r_o_status <= r_a_status;
            r_o_temp   <= w_temp;
            r_o_hum    <= w_hum;
            r_o_traw   <= r_a_traw;
            r_o_hraw   <= r_a_hraw;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {3'b000, r_o_hraw, r_o_traw, r_o_hum, r_o_temp};

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the humidity/temperature frame decoder: framing, CRC and conversion.
`timescale 1ns / 1ps

module tb;

    // one byte beat on the input stream
    typedef struct {
        logic [7:0] value;
        logic       first;
    } t_byte_beat;

    // one decoded reading on the output stream
    typedef struct {
        htfd_pkg::t_status                    status;
        logic signed [htfd_pkg::TEMP_W-1:0]   temp_centi;
        logic [htfd_pkg::HUM_W-1:0]           hum_centi;
        logic [htfd_pkg::RAW_W-1:0]           temp_raw;
        logic [htfd_pkg::RAW_W-1:0]           hum_raw;
    } t_reading;

    localparam int ITEM_TARGET = 1250;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int IDLE_PCT    = 26;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    t_byte_beat byte_queue[$];
    t_reading   pending_results[$];

    // decoder state as predicted, starting from the reset values
    logic [2:0]  frm_pos      = htfd_pkg::POS_T_MSB;
    logic [7:0]  frm_crc      = htfd_pkg::CRC_INIT;
    logic [15:0] frm_temp     = 16'h0000;
    logic [7:0]  frm_hum_hi   = 8'h00;
    logic [7:0]  frm_hum_lo   = 8'h00;
    logic        frm_temp_bad = 1'b0;

    int errors     = 0;
    int in_beats   = 0;
    int out_beats  = 0;
    int cycle_no   = 0;
    int hold_left  = 0;
    int hold_stage = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    logic calm;

    humidity_temp_frame_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // CRC-8 over one byte, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] crc8_word(input logic [15:0] w);
        return crc8_step(crc8_step(htfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // raw word biased towards the ends of the range
    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // advance the frame decoder by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic first);
        logic [2:0] pos;
        t_reading   r;
        longint     t_ticks;
        longint     h_ticks;
        longint     tv;
        longint     hv;
        pos = frm_pos;
        if (first || pos > htfd_pkg::POS_H_CRC) pos = htfd_pkg::POS_T_MSB;
        if (pos == htfd_pkg::POS_T_MSB || pos == htfd_pkg::POS_H_MSB) frm_crc = htfd_pkg::CRC_INIT;
        case (pos)
            htfd_pkg::POS_T_MSB: begin
                frm_temp = {b, 8'h00};
                frm_crc  = crc8_step(frm_crc, b);
            end
            htfd_pkg::POS_T_LSB: begin
                frm_temp[7:0] = b;
                frm_crc       = crc8_step(frm_crc, b);
            end
            htfd_pkg::POS_T_CRC: frm_temp_bad = (frm_crc != b);
            htfd_pkg::POS_H_MSB: begin
                frm_hum_hi = b;
                frm_crc    = crc8_step(frm_crc, b);
            end
            htfd_pkg::POS_H_LSB: begin
                frm_hum_lo = b;
                frm_crc    = crc8_step(frm_crc, b);
            end
            default: begin
                // humidity CRC byte closes the frame
                r.temp_raw   = frm_temp;
                r.hum_raw    = {frm_hum_hi, frm_hum_lo};
                r.temp_centi = '0;
                r.hum_centi  = '0;
                if (frm_temp_bad) begin
                    r.status = htfd_pkg::ST_TEMP_CRC;
                end else if (frm_crc != b) begin
                    r.status = htfd_pkg::ST_HUM_CRC;
                end else begin
                    r.status = htfd_pkg::ST_OK;
                    t_ticks  = r.temp_raw;
                    h_ticks  = r.hum_raw;
                    tv = -4500 + (17500 * t_ticks) / 65535;
                    hv = -600 + (12500 * h_ticks) / 65535;
                    if (hv < 0) hv = 0;
                    if (hv > 10000) hv = 10000;
                    r.temp_centi = tv[htfd_pkg::TEMP_W-1:0];
                    r.hum_centi  = hv[htfd_pkg::HUM_W-1:0];
                end
                pending_results.push_back(r);
                frm_crc      = htfd_pkg::CRC_INIT;
                frm_temp_bad = 1'b0;
            end
        endcase
        frm_pos = (pos == htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : pos + 3'd1;
    endtask

    // queue the first n_beats bytes of a frame, with optional CRC corruption
    task automatic queue_frame(input logic [15:0] tw, input logic [15:0] hw, input logic first,
                               input bit bad_t, input bit bad_h, input int n_beats);
        logic [7:0] tc;
        logic [7:0] hc;
        t_byte_beat beats[6];
        tc = crc8_word(tw);
        hc = crc8_word(hw);
        if (bad_t) tc ^= 8'($urandom_range(1, 255));
        if (bad_h) hc ^= 8'($urandom_range(1, 255));
        beats[0] = '{tw[15:8], first};
        beats[1] = '{tw[7:0], 1'b0};
        beats[2] = '{tc, 1'b0};
        beats[3] = '{hw[15:8], 1'b0};
        beats[4] = '{hw[7:0], 1'b0};
        beats[5] = '{hc, 1'b0};
        for (int i = 0; i < n_beats; i++) byte_queue.push_back(beats[i]);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at result %0d, %s: got %0h, expected %0h", out_beats, field, got, want);
        errors++;
    endtask

    // cycle count and a window where neither side idles
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end
    assign calm = (cycle_no >= 700) && (cycle_no < 1100);

    // input driver: offers queued bytes, idles at random
    always @(posedge i_clk) begin : drive
        t_byte_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = byte_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.value;
                s_axis_tuser  <= nxt.first;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predict on every accepted byte beat
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            decode_byte(s_axis_tdata, s_axis_tuser);
            in_beats <= in_beats + 1;
        end
    end

    // output sink: random stalls plus two long hold-offs to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if ((hold_stage == 0 && in_beats >= 300) ||
                     (hold_stage == 1 && in_beats >= 900)) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_stage    <= hold_stage + 1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result checker
    always @(posedge i_clk) begin : check
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            out_beats++;
            status_seen[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", m_axis_tdata, 64'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[14:0] != want.temp_centi)
                    report_mismatch("temperature_centi", m_axis_tdata[14:0], want.temp_centi);
                if (m_axis_tdata[28:15] != want.hum_centi)
                    report_mismatch("humidity_centi", m_axis_tdata[28:15], want.hum_centi);
                if (m_axis_tdata[44:29] != want.temp_raw)
                    report_mismatch("temperature_raw", m_axis_tdata[44:29], want.temp_raw);
                if (m_axis_tdata[60:45] != want.hum_raw)
                    report_mismatch("humidity_raw", m_axis_tdata[60:45], want.hum_raw);
                if (m_axis_tdata[63:61] != 3'b000)
                    report_mismatch("tdata padding", m_axis_tdata[63:61], 64'h0);
            end
        end
    end

    // stimulus and end of run
    initial begin : stim
        int r;
        // directed frames
        queue_frame(16'h0000, 16'h0000, 1'b1, 0, 0, 6);  // coldest; humidity clamps to zero
        queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 6);  // no start flag; humidity clamps high
        queue_frame(16'h6666, 16'h8000, 1'b1, 0, 0, 2);  // abandoned after two bytes
        queue_frame(16'h1234, 16'h5678, 1'b1, 1, 1, 6);  // restart mid-frame, both CRCs bad
        queue_frame(16'hBEEF, 16'hC0DE, 1'b1, 0, 1, 6);  // humidity CRC bad only

        // random: mostly whole frames, some truncated frames and loose bytes
        while (byte_queue.size() < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 75) begin
                queue_frame(pick_word(), pick_word(), $urandom_range(9) != 0,
                            $urandom_range(99) < 15, $urandom_range(99) < 15, 6);
            end else if (r < 87) begin
                queue_frame(pick_word(), pick_word(), 1'($urandom_range(1)),
                            0, 0, $urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 4))
                    byte_queue.push_back('{8'($urandom), 1'($urandom)});
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d byte beats and %0d readings: %0d good, %0d temperature CRC,",
                 in_beats, out_beats, status_seen[htfd_pkg::ST_OK],
                 status_seen[htfd_pkg::ST_TEMP_CRC]);
        $display("%0d humidity CRC; output held off %0d times for %0d cycles; %0d errors",
                 status_seen[htfd_pkg::ST_HUM_CRC], hold_stage, HOLD_CYCLES, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Timeout waiting for the decoder");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
